/* design/vcs_pkg.sv */
// Shared constants, types and helpers for the Verlet chain step block.
package vcs_pkg;

    localparam int MAX_POINTS = 64;
    localparam int PT_W       = $clog2(MAX_POINTS);
    localparam int CNT_W      = PT_W + 1;
    localparam int FRAC_BITS  = 16;

    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 72;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;

    localparam int DRAG_W  = 17;
    localparam int GRAV_W  = 24;
    localparam int REST_W  = 24;
    localparam int SWEEP_W = 10;
    localparam int DT_W    = 16;

    localparam int DVS_W = 33;
    localparam int DVD_W = DVS_W + REST_W;

    localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DRAG_FACTOR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REST_DISTANCE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RELAX_SWEEPS  = 3'd4;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    typedef logic signed [31:0] coord_t;

    function automatic coord_t sat32(input logic signed [63:0] v);
        coord_t r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

/* design/vcs_div.sv */
// Unsigned restoring divider, one quotient bit per cycle.
module vcs_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [vcs_pkg::DVD_W-1:0]  dividend,
    input  logic [vcs_pkg::DVS_W-1:0]  divisor,
    output logic                       done,
    output logic [vcs_pkg::DVD_W-1:0]  quotient
);
    import vcs_pkg::*;

    localparam int CW = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] dvd_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DVS_W:0]   rem_sh;
    logic             fit;

    assign rem_sh = {rem_reg, dvd_reg[DVD_W-1]};
    assign fit    = rem_sh >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DVD_W);
                dvd_reg  <= dividend;
                dvs_reg  <= divisor;
                rem_reg  <= '0;
            end else if (busy_reg) begin
                rem_reg <= fit ? DVS_W'(rem_sh - {1'b0, dvs_reg}) : rem_sh[DVS_W-1:0];
                dvd_reg <= {dvd_reg[DVD_W-2:0], fit};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

/* design/verlet_chain_step.sv */
// Top level of the Verlet chain step block.
//
// Input channel s_*: one beat per item. s_tuser is the operation (0 load, 1 step).
// A load beat writes one point's current and previous position and gives no
// output. A step beat moves all free points, runs relax_sweeps relaxation
// sweeps and then emits one m_* beat per point in use, m_tlast on the last.
// Configuration is a plain write port (cfg_wr_en, cfg_index, cfg_data).
// One item is worked on at a time; s_tready is high only while idle.
// Each pair of a sweep is bound by a square root and a divide;
// x and y divides run side by side.
// Point positions live in two 64-entry memories (current and previous position)
// with a registered read port.
// Reset restores the register defaults and marks all entries as zero.
// When m_tready is low the emitting beat holds and the sequencer waits.
module verlet_chain_step (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [vcs_pkg::S_TDATA_W-1:0]     s_tdata,  // point_index, pos_x, pos_y, step_time
    input  logic                              s_tuser,  // operation
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [vcs_pkg::M_TDATA_W-1:0]     m_tdata,  // out_index, out_x, out_y
    output logic                              m_tlast,
    input  logic                              cfg_wr_en,
    input  logic [vcs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [vcs_pkg::CFG_DAT_W-1:0]     cfg_data
);
    import vcs_pkg::*;

    localparam logic [4:0] ST_IDLE      = 5'd0;
    localparam logic [4:0] ST_G1        = 5'd1;
    localparam logic [4:0] ST_G2        = 5'd2;
    localparam logic [4:0] ST_MV_RD     = 5'd3;
    localparam logic [4:0] ST_MV_MUL    = 5'd4;
    localparam logic [4:0] ST_MV_WR     = 5'd5;
    localparam logic [4:0] ST_RLX_START = 5'd6;
    localparam logic [4:0] ST_RLX_RD0   = 5'd7;
    localparam logic [4:0] ST_RLX_LD0   = 5'd8;
    localparam logic [4:0] ST_PAIR_RD   = 5'd9;
    localparam logic [4:0] ST_PAIR_D    = 5'd10;
    localparam logic [4:0] ST_SQ        = 5'd11;
    localparam logic [4:0] ST_SUM       = 5'd12;
    localparam logic [4:0] ST_SQRT      = 5'd13;
    localparam logic [4:0] ST_DLEN      = 5'd14;
    localparam logic [4:0] ST_DIVGO     = 5'd15;
    localparam logic [4:0] ST_DIV       = 5'd16;
    localparam logic [4:0] ST_CORR      = 5'd17;
    localparam logic [4:0] ST_ADV       = 5'd18;
    localparam logic [4:0] ST_SWEEP_END = 5'd19;
    localparam logic [4:0] ST_EM_RD     = 5'd20;
    localparam logic [4:0] ST_EM_LD     = 5'd21;
    localparam logic [4:0] ST_EM_WAIT   = 5'd22;

    // configuration
    logic [CNT_W-1:0]   pcount_reg;
    logic [DRAG_W-1:0]  drag_reg;
    logic [GRAV_W-1:0]  grav_reg;
    logic [REST_W-1:0]  rest_reg;
    logic [SWEEP_W-1:0] sweeps_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pcount_reg <= CNT_W'(64);
            drag_reg   <= DRAG_W'(64880);
            grav_reg   <= GRAV_W'(642252);
            rest_reg   <= REST_W'(65536);
            sweeps_reg <= SWEEP_W'(600);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_POINT_COUNT:   pcount_reg <= cfg_data[CNT_W-1:0];
                REG_DRAG_FACTOR:   drag_reg   <= cfg_data[DRAG_W-1:0];
                REG_GRAVITY:       grav_reg   <= cfg_data[GRAV_W-1:0];
                REG_REST_DISTANCE: rest_reg   <= cfg_data[REST_W-1:0];
                REG_RELAX_SWEEPS:  sweeps_reg <= cfg_data[SWEEP_W-1:0];
                default: ;
            endcase
        end
    end

    logic [CNT_W-1:0]  n_eff;
    logic [DRAG_W-1:0] drag_eff;
    always_comb begin
        if (pcount_reg < CNT_W'(1)) begin
            n_eff = CNT_W'(1);
        end else if (pcount_reg > CNT_W'(MAX_POINTS)) begin
            n_eff = CNT_W'(MAX_POINTS);
        end else begin
            n_eff = pcount_reg;
        end
        drag_eff = (drag_reg > DRAG_W'(1 << FRAC_BITS)) ? DRAG_W'(1 << FRAC_BITS) : drag_reg;
    end

    // memories
    logic [63:0]           cur_mem  [MAX_POINTS];
    logic [63:0]           prev_mem [MAX_POINTS];
    logic [MAX_POINTS-1:0] vld_reg;
    logic [63:0]           cur_q_reg, prev_q_reg;
    logic                  vld_q_reg;
    logic [63:0]           cur_rd, prev_rd;

    logic              wr_en, wr_prev_en;
    logic [PT_W-1:0]   wr_addr;
    logic [63:0]       wr_cur, wr_prev;

    logic [4:0]        state_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [SWEEP_W-1:0] sweep_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            cur_mem[wr_addr] <= wr_cur;
        end
        if (wr_prev_en) begin
            prev_mem[wr_addr] <= wr_prev;
        end
        cur_q_reg  <= cur_mem[idx_reg[PT_W-1:0]];
        prev_q_reg <= prev_mem[idx_reg[PT_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg   <= '0;
            vld_q_reg <= 1'b0;
        end else begin
            vld_q_reg <= vld_reg[idx_reg[PT_W-1:0]];
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
        end
    end

    assign cur_rd  = vld_q_reg ? cur_q_reg : 64'd0;
    assign prev_rd = vld_q_reg ? prev_q_reg : 64'd0;

    // datapath registers
    logic [DT_W-1:0]       dt_reg;
    logic [GRAV_W+DT_W-1:0] gdt_reg;
    logic [24:0]           gterm_reg;
    coord_t                cx_reg, cy_reg;
    logic signed [50:0]    mvx_reg, mvy_reg;
    coord_t                carry_x_reg, carry_y_reg, ci_x_reg, ci_y_reg;
    logic signed [32:0]    dx_reg, dy_reg;
    logic [32:0]           adx_reg, ady_reg;
    logic [31:0]           hx_reg, hy_reg;
    logic                  halved_reg;
    logic [63:0]           sqx_reg, sqy_reg, sq_val_reg;
    logic [32:0]           sq_rem_reg;
    logic [31:0]           sq_root_reg;
    logic [5:0]            sq_cnt_reg;
    logic [DVS_W-1:0]      d_reg;
    logic [DVD_W-1:0]      px_reg, py_reg;
    logic                  div_start;
    logic                  div_done_x, div_done_y;
    logic [DVD_W-1:0]      qx, qy;

    logic [5:0]            out_idx_reg;
    coord_t                out_x_reg, out_y_reg;
    logic                  out_last_reg, m_tvalid_reg;

    // combinational helpers
    coord_t             rd_x, rd_y;
    logic signed [32:0] dx_c, dy_c;
    logic [32:0]        adx_c, ady_c;
    logic signed [32:0] hx_s, hy_s;
    logic               halved_c;
    logic [34:0]        rem_sh, trial;
    logic signed [34:0] tx, ty;
    coord_t             mv_x, mv_y;
    logic signed [58:0] qsx, qsy, dfx, dfy, offx, offy;
    coord_t             new_ix, new_iy, new_px, new_py;

    assign rd_x = cur_rd[31:0];
    assign rd_y = cur_rd[63:32];

    always_comb begin
        dx_c = 33'(rd_x) - 33'(carry_x_reg);
        dy_c = 33'(rd_y) - 33'(carry_y_reg);
        adx_c = dx_c[32] ? 33'(-dx_c) : 33'(dx_c);
        ady_c = dy_c[32] ? 33'(-dy_c) : 33'(dy_c);
        halved_c = adx_c[32] | adx_c[31] | ady_c[32] | ady_c[31];
        hx_s = halved_c ? (dx_c >>> 1) : dx_c;
        hy_s = halved_c ? (dy_c >>> 1) : dy_c;

        rem_sh = {sq_rem_reg, sq_val_reg[63:62]};
        trial  = {1'b0, sq_root_reg, 2'b01};

        tx = 35'((mvx_reg + 51'sd32768) >>> FRAC_BITS);
        ty = 35'((mvy_reg + 51'sd32768) >>> FRAC_BITS);
        mv_x = sat32(64'(cx_reg) + 64'(tx));
        mv_y = sat32(64'(cy_reg) + 64'(ty) - $signed({39'd0, gterm_reg}));

        qsx = dx_reg[32] ? -$signed({2'b00, qx}) : $signed({2'b00, qx});
        qsy = dy_reg[32] ? -$signed({2'b00, qy}) : $signed({2'b00, qy});
        dfx = 59'(dx_reg) - qsx;
        dfy = 59'(dy_reg) - qsy;
        offx = (dfx + $signed({58'd0, dfx[58]})) >>> 1;
        offy = (dfy + $signed({58'd0, dfy[58]})) >>> 1;
        new_ix = sat32(64'(ci_x_reg) - 64'(offx));
        new_iy = sat32(64'(ci_y_reg) - 64'(offy));
        new_px = sat32(64'(carry_x_reg) + 64'(offx));
        new_py = sat32(64'(carry_y_reg) + 64'(offy));
    end

    // memory write port and divider start
    always_comb begin
        wr_en      = 1'b0;
        wr_prev_en = 1'b0;
        wr_addr    = idx_reg[PT_W-1:0];
        wr_cur     = {cy_reg, cx_reg};
        wr_prev    = {cy_reg, cx_reg};
        div_start  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                wr_addr = s_tdata[PT_W-1:0];
                wr_cur  = {s_tdata[69:38], s_tdata[37:6]};
                wr_prev = {s_tdata[69:38], s_tdata[37:6]};
                if (s_tvalid && s_tuser == OP_LOAD) begin
                    wr_en      = 1'b1;
                    wr_prev_en = 1'b1;
                end
            end
            ST_MV_WR: begin
                wr_en      = 1'b1;
                wr_prev_en = 1'b1;
                if (idx_reg != '0) begin
                    wr_cur = {mv_y, mv_x};
                end
            end
            ST_DLEN: begin
                // zero-length pair: store the lower point unchanged
                wr_addr = PT_W'(idx_reg - 1'b1);
                wr_cur  = {carry_y_reg, carry_x_reg};
                if (sq_root_reg == '0) begin
                    wr_en = 1'b1;
                end
            end
            ST_CORR: begin
                wr_en   = 1'b1;
                wr_addr = PT_W'(idx_reg - 1'b1);
                wr_cur  = (idx_reg == CNT_W'(1)) ? {carry_y_reg, carry_x_reg}
                                                 : {new_py, new_px};
            end
            ST_SWEEP_END: begin
                wr_en  = 1'b1;
                wr_cur = {carry_y_reg, carry_x_reg};
            end
            ST_DIVGO: div_start = 1'b1;
            default: ;
        endcase
    end

    vcs_div u_div_x (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (px_reg),
        .divisor  (d_reg),
        .done     (div_done_x),
        .quotient (qx)
    );

    vcs_div u_div_y (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (py_reg),
        .divisor  (d_reg),
        .done     (div_done_y),
        .quotient (qy)
    );

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            sweep_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid && s_tuser == OP_STEP) begin
                        dt_reg    <= s_tdata[85:70];
                        state_reg <= ST_G1;
                    end
                end
                ST_G1: begin
                    gdt_reg   <= grav_reg * dt_reg;
                    state_reg <= ST_G2;
                end
                ST_G2: begin
                    gterm_reg <= 25'((57'(gdt_reg) * 57'(dt_reg) + 57'd2147483648) >> 32);
                    idx_reg   <= '0;
                    state_reg <= ST_MV_RD;
                end
                ST_MV_RD: state_reg <= ST_MV_MUL;
                ST_MV_MUL: begin
                    cx_reg    <= rd_x;
                    cy_reg    <= rd_y;
                    mvx_reg   <= (33'(rd_x) - 33'($signed(prev_rd[31:0])))
                                 * $signed({1'b0, drag_eff});
                    mvy_reg   <= (33'(rd_y) - 33'($signed(prev_rd[63:32])))
                                 * $signed({1'b0, drag_eff});
                    state_reg <= ST_MV_WR;
                end
                ST_MV_WR: begin
                    if (idx_reg == n_eff - 1'b1) begin
                        sweep_reg <= '0;
                        idx_reg   <= '0;
                        state_reg <= (n_eff > CNT_W'(1) && sweeps_reg != '0)
                                     ? ST_RLX_START : ST_EM_RD;
                    end else begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= ST_MV_RD;
                    end
                end
                ST_RLX_START: begin
                    idx_reg   <= '0;
                    state_reg <= ST_RLX_RD0;
                end
                ST_RLX_RD0: state_reg <= ST_RLX_LD0;
                ST_RLX_LD0: begin
                    carry_x_reg <= rd_x;
                    carry_y_reg <= rd_y;
                    idx_reg     <= CNT_W'(1);
                    state_reg   <= ST_PAIR_RD;
                end
                ST_PAIR_RD: state_reg <= ST_PAIR_D;
                ST_PAIR_D: begin
                    ci_x_reg   <= rd_x;
                    ci_y_reg   <= rd_y;
                    dx_reg     <= dx_c;
                    dy_reg     <= dy_c;
                    adx_reg    <= adx_c;
                    ady_reg    <= ady_c;
                    halved_reg <= halved_c;
                    hx_reg     <= hx_s[32] ? 32'(-hx_s) : 32'(hx_s);
                    hy_reg     <= hy_s[32] ? 32'(-hy_s) : 32'(hy_s);
                    state_reg  <= ST_SQ;
                end
                ST_SQ: begin
                    sqx_reg   <= hx_reg * hx_reg;
                    sqy_reg   <= hy_reg * hy_reg;
                    state_reg <= ST_SUM;
                end
                ST_SUM: begin
                    sq_val_reg  <= sqx_reg + sqy_reg;
                    sq_rem_reg  <= '0;
                    sq_root_reg <= '0;
                    sq_cnt_reg  <= 6'd32;
                    state_reg   <= ST_SQRT;
                end
                ST_SQRT: begin
                    if (rem_sh >= trial) begin
                        sq_rem_reg  <= 33'(rem_sh - trial);
                        sq_root_reg <= {sq_root_reg[30:0], 1'b1};
                    end else begin
                        sq_rem_reg  <= rem_sh[32:0];
                        sq_root_reg <= {sq_root_reg[30:0], 1'b0};
                    end
                    sq_val_reg <= {sq_val_reg[61:0], 2'b00};
                    sq_cnt_reg <= sq_cnt_reg - 1'b1;
                    if (sq_cnt_reg == 6'd1) begin
                        state_reg <= ST_DLEN;
                    end
                end
                ST_DLEN: begin
                    d_reg  <= halved_reg ? {sq_root_reg, 1'b0} : {1'b0, sq_root_reg};
                    px_reg <= adx_reg * rest_reg;
                    py_reg <= ady_reg * rest_reg;
                    if (sq_root_reg == '0) begin
                        // zero-length pair: no correction
                        carry_x_reg <= ci_x_reg;
                        carry_y_reg <= ci_y_reg;
                        state_reg   <= ST_ADV;
                    end else begin
                        state_reg <= ST_DIVGO;
                    end
                end
                ST_DIVGO: state_reg <= ST_DIV;
                ST_DIV: begin
                    if (div_done_x && div_done_y) begin
                        state_reg <= ST_CORR;
                    end
                end
                ST_CORR: begin
                    carry_x_reg <= new_ix;
                    carry_y_reg <= new_iy;
                    state_reg   <= ST_ADV;
                end
                ST_ADV: begin
                    if (idx_reg == n_eff - 1'b1) begin
                        state_reg <= ST_SWEEP_END;
                    end else begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= ST_PAIR_RD;
                    end
                end
                ST_SWEEP_END: begin
                    if (sweep_reg == sweeps_reg - 1'b1) begin
                        idx_reg   <= '0;
                        state_reg <= ST_EM_RD;
                    end else begin
                        sweep_reg <= sweep_reg + 1'b1;
                        state_reg <= ST_RLX_START;
                    end
                end
                ST_EM_RD: state_reg <= ST_EM_LD;
                ST_EM_LD: begin
                    out_idx_reg  <= idx_reg[5:0];
                    out_x_reg    <= rd_x;
                    out_y_reg    <= rd_y;
                    out_last_reg <= idx_reg == n_eff - 1'b1;
                    m_tvalid_reg <= 1'b1;
                    state_reg    <= ST_EM_WAIT;
                end
                ST_EM_WAIT: begin
                    if (m_tready) begin
                        m_tvalid_reg <= 1'b0;
                        if (out_last_reg) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= ST_EM_RD;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, out_y_reg, out_x_reg, out_idx_reg};
    assign m_tlast  = out_last_reg;

endmodule

/* design/vcs_chk.sv */
// Port-level checker for the Verlet chain step block, bound to the top level.
module vcs_chk (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [vcs_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tlast
);
    import vcs_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output beat changed while stalled");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid)
        else $error("input taken while output beat pending");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_load_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == OP_LOAD |=> !m_tvalid && s_tready)
        else $error("load beat produced output or stalled");

endmodule

bind verlet_chain_step vcs_chk u_vcs_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
